>>> rtl/apq_pkg.sv
`default_nettype none
package apq_pkg;

  // field widths of the stream and register items
  localparam int FIELD_W = 32;
  localparam int MAG_W   = 31;
  localparam int PPM_W   = 24;
  localparam int CHUNK_W = 16;
  localparam int FRAC_W  = 17;
  localparam int DIFF_W  = 33;
  localparam int DIGIT_W = 8;
  localparam int PROD_W  = DIFF_W + DIGIT_W + 1;
  localparam int SUM_W   = 58;
  localparam int WHOLE_W = SUM_W - 24;
  localparam int DOM_W   = 2;

  // sequencer state codes
  typedef logic [3:0] state_t;
  localparam state_t ST_IDLE  = 4'd0;
  localparam state_t ST_DIFF  = 4'd1;
  localparam state_t ST_MUL   = 4'd2;
  localparam state_t ST_SUM   = 4'd3;
  localparam state_t ST_QUANT = 4'd4;
  localparam state_t ST_CMP   = 4'd5;
  localparam state_t ST_CPREP = 4'd6;
  localparam state_t ST_DCHK  = 4'd7;
  localparam state_t ST_DIV   = 4'd8;
  localparam state_t ST_DONE  = 4'd9;

endpackage
`default_nettype wire

>>> rtl/axis_pulse_quantizer_top.sv
`default_nettype none
// channel  | dir | handshake                  | payload
// s_axis   | in  | s_tvalid / s_tready        | s_tdata: target, current, missed per axis
// m_axis   | out | m_tvalid / m_tready        | m_tdata: pulses, negative, dominant, chunks
// apb      | in  | psel, penable, pwrite      | paddr / pwdata / prdata, pready tied high
//
// each move passes through the shared 33x8 shift-add multiplier (three digit
// steps per axis) and the bit-serial 16-step chunk divider; a new move is
// taken only after the sequencer has gone back to idle
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register, so the next move is taken while it is pending
// rst clears the sequencer, the fraction carries and the registers to defaults
module axis_pulse_quantizer_top import apq_pkg::*; #(
  parameter int AXES = 3
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // s_tdata fields from bit 0: target per axis, current per axis, missed per axis
  input  wire logic [3*AXES*FIELD_W-1:0] s_tdata,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // m_tdata fields from bit 0: pulses per axis, negative per axis, dominant_axis,
  // dominant_pulses, chunk_count, zero padding
  output logic [((AXES*(MAG_W+1)+DOM_W+MAG_W+CHUNK_W+7)/8)*8-1:0] m_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [$clog2(4*(AXES+1))-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int AW      = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int PA_W    = $clog2(4*(AXES+1));
  localparam int IDX_W   = PA_W - 2;
  localparam int OUT_BITS = AXES*(MAG_W+1) + DOM_W + MAG_W + CHUNK_W;
  localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8;
  localparam int NEG_LO  = AXES*MAG_W;
  localparam int DAX_LO  = NEG_LO + AXES;
  localparam int DMAG_LO = DAX_LO + DOM_W;
  localparam int CHK_LO  = DMAG_LO + MAG_W;
  localparam logic [DOM_W-1:0] NONE_AXIS = DOM_W'(AXES);
  localparam logic [AW-1:0] LAST_AXIS = AW'(AXES-1);

  // registers
  logic [PPM_W-1:0]          ppm [AXES];
  logic [CHUNK_W-1:0]        chunk_pulses;
  logic signed [FRAC_W-1:0]  carry [AXES];
  logic [3*AXES*FIELD_W-1:0] in_reg;
  state_t                    state;
  logic [AW-1:0]             axis;
  logic [1:0]                dig;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [SUM_W-1:0]   acc;
  logic signed [SUM_W-1:0]   sum;
  logic [MAG_W-1:0]          cur_mag;
  logic [MAG_W-1:0]          lane_mag [AXES];
  logic                      lane_neg [AXES];
  logic [MAG_W-1:0]          dom_mag;
  logic [DOM_W-1:0]          dom_axis;
  logic [31:0]               num;
  logic [CHUNK_W-1:0]        rem;
  logic [CHUNK_W-1:0]        quot;
  logic [3:0]                div_cnt;
  logic                      chunk_sat;

  // combinational datapath
  logic [IDX_W-1:0]          cfg_idx;
  logic                      cfg_wr;
  logic [CHUNK_W-1:0]        chunk_eff;
  logic signed [FIELD_W-1:0] tgt_sel;
  logic signed [FIELD_W-1:0] cur_sel;
  logic signed [FIELD_W-1:0] mis_sel;
  logic [DIGIT_W-1:0]        digit;
  logic signed [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]          mag_full;
  logic [WHOLE_W-1:0]        whole_mag;
  logic [CHUNK_W-1:0]        rem16;
  logic [CHUNK_W:0]          trial;
  logic                      trial_ge;
  logic [OUT_W-1:0]          out_pack;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[PA_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign chunk_eff = (chunk_pulses == '0) ? CHUNK_W'(1) : chunk_pulses;
  assign s_tready = (state == ST_IDLE);

  // register read mux
  always_comb begin
    prdata = '0;
    if (int'(cfg_idx) < AXES) begin
      prdata = 32'(ppm[cfg_idx[AW-1:0]]);
    end else if (int'(cfg_idx) == AXES) begin
      prdata = 32'(chunk_pulses);
    end
  end

  // operand select for the current axis
  assign tgt_sel = $signed(in_reg[FIELD_W*int'(axis) +: FIELD_W]);
  assign cur_sel = $signed(in_reg[FIELD_W*(AXES+int'(axis)) +: FIELD_W]);
  assign mis_sel = $signed(in_reg[FIELD_W*(2*AXES+int'(axis)) +: FIELD_W]);
  assign digit   = ppm[axis][DIGIT_W*int'(dig) +: DIGIT_W];

  // shared multiplier: difference times one rate digit
  assign prod = diff * $signed({1'b0, digit});

  // truncation toward zero through the magnitude
  assign mag_full  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign whole_mag = mag_full[SUM_W-1:24];
  assign rem16     = mag_full[23:8];

  // restoring divider step
  assign trial    = {rem, quot[CHUNK_W-1]};
  assign trial_ge = (trial >= {1'b0, chunk_eff});

  // result packing
  always_comb begin
    out_pack = '0;
    for (int i = 0; i < AXES; i++) begin
      out_pack[MAG_W*i +: MAG_W] = lane_mag[i];
      out_pack[NEG_LO + i]       = lane_neg[i];
    end
    out_pack[DAX_LO +: DOM_W]    = dom_axis;
    out_pack[DMAG_LO +: MAG_W]   = dom_mag;
    out_pack[CHK_LO +: CHUNK_W]  = chunk_sat ? {CHUNK_W{1'b1}} : quot;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        ppm[i] <= PPM_W'(256);
      end
      chunk_pulses <= CHUNK_W'(1);
    end else if (cfg_wr) begin
      if (int'(cfg_idx) < AXES) begin
        ppm[cfg_idx[AW-1:0]] <= pwdata[PPM_W-1:0];
      end else if (int'(cfg_idx) == AXES) begin
        chunk_pulses <= pwdata[CHUNK_W-1:0];
      end
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        carry[i] <= '0;
      end
    end else begin
      // the done state drives m_tvalid itself
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (dig == 2'd0) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          state <= ST_QUANT;
        end
        ST_QUANT: begin
          carry[axis] <= sum[SUM_W-1] ? -$signed({1'b0, rem16}) : $signed({1'b0, rem16});
          state <= ST_CMP;
        end
        ST_CMP: begin
          state <= (axis == LAST_AXIS) ? ST_CPREP : ST_DIFF;
        end
        ST_CPREP: begin
          state <= ST_DCHK;
        end
        ST_DCHK: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_cnt == 4'd15) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        in_reg   <= s_tdata;
        axis     <= '0;
        dom_mag  <= '0;
        dom_axis <= NONE_AXIS;
      end
      ST_DIFF: begin
        diff <= DIFF_W'(tgt_sel) - DIFF_W'(cur_sel);
        acc  <= '0;
        dig  <= 2'd2;
      end
      ST_MUL: begin
        acc <= (acc <<< DIGIT_W) + SUM_W'(prod);
        dig <= dig - 2'd1;
      end
      ST_SUM: begin
        sum <= acc + (SUM_W'(mis_sel) <<< 16) + (SUM_W'(carry[axis]) <<< 8);
      end
      ST_QUANT: begin
        cur_mag        <= (|whole_mag[WHOLE_W-1:MAG_W]) ? {MAG_W{1'b1}}
                                                        : whole_mag[MAG_W-1:0];
        lane_mag[axis] <= (|whole_mag[WHOLE_W-1:MAG_W]) ? {MAG_W{1'b1}}
                                                        : whole_mag[MAG_W-1:0];
        lane_neg[axis] <= sum[SUM_W-1] || (whole_mag == '0);
      end
      ST_CMP: begin
        if (cur_mag > dom_mag) begin
          dom_mag  <= cur_mag;
          dom_axis <= DOM_W'(axis);
        end
        axis <= axis + AW'(1);
      end
      ST_CPREP: begin
        num <= 32'(dom_mag) + 32'(chunk_eff) - 32'd1;
      end
      ST_DCHK: begin
        chunk_sat <= (num[31:16] >= chunk_eff);
        rem       <= num[31:16];
        quot      <= num[15:0];
        div_cnt   <= '0;
      end
      ST_DIV: begin
        rem     <= trial_ge ? CHUNK_W'(trial - {1'b0, chunk_eff}) : trial[CHUNK_W-1:0];
        quot    <= {quot[CHUNK_W-2:0], trial_ge};
        div_cnt <= div_cnt + 4'd1;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= out_pack;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a move is in progress");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && !chunk_sat |-> rem < chunk_eff)
    else $error("divider remainder not below chunk size");

  a_none_means_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[DAX_LO +: DOM_W] == NONE_AXIS) ==
                  (m_tdata[DMAG_LO +: MAG_W] == '0)))
    else $error("dominant axis and dominant pulses disagree");

  a_chunks_bounded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 31'(m_tdata[CHK_LO +: CHUNK_W]) <= m_tdata[DMAG_LO +: MAG_W])
    else $error("chunk count exceeds dominant pulses");

  a_zero_is_negative: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[MAG_W-1:0] == '0) |-> m_tdata[NEG_LO])
    else $error("zero count without direction bit");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench import apq_pkg::*; ();

  localparam int NUM_AXES    = 3;
  localparam int ADDR_W      = $clog2(4 * (NUM_AXES + 1));
  // accept-to-result latency plus a little margin
  localparam int DRAIN_CYCLES = 7 * NUM_AXES + 20 + 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_MOVES   = 135;

  localparam logic [FIELD_W-1:0] ONE_MM  = 32'h0001_0000;
  localparam logic [FIELD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] POS_MIN = 32'h8000_0000;

  localparam longint PULSE_ONE  = 64'sd16777216;
  localparam longint MAG_LIMIT  = 64'sd2147483647;
  localparam longint CHUNK_SAT  = 64'sd65535;

  typedef enum int {
    REG_PPM_X = 0,
    REG_PPM_Y = 1,
    REG_PPM_Z = 2,
    REG_CHUNK = 3
  } reg_idx_t;

  typedef enum logic [DOM_W-1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } dom_axis_t;

  // one move as carried on s_tdata, target of axis 0 in the lowest bits
  typedef struct packed {
    logic [NUM_AXES-1:0][FIELD_W-1:0] missed;
    logic [NUM_AXES-1:0][FIELD_W-1:0] current;
    logic [NUM_AXES-1:0][FIELD_W-1:0] target;
  } move_t;

  // one result as carried on m_tdata, pulses of axis 0 in the lowest bits
  typedef struct packed {
    logic [6:0]                       pad;
    logic [CHUNK_W-1:0]               chunk_count;
    logic [MAG_W-1:0]                 dominant_pulses;
    logic [DOM_W-1:0]                 dominant_axis;
    logic [NUM_AXES-1:0]              negative;
    logic [NUM_AXES-1:0][MAG_W-1:0]   pulses;
  } pulse_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  // s_tdata fields from bit 0: target x/y/z, current x/y/z, missed x/y/z
  logic [$bits(move_t)-1:0]    s_tdata = '0;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  // m_tdata fields from bit 0: pulses x/y/z, negative x/y/z, dominant_axis,
  // dominant_pulses, chunk_count, zero padding
  logic [$bits(pulse_result_t)-1:0] m_tdata;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ADDR_W-1:0]           paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  // shadow of the block's registers and fraction carries
  logic [PPM_W-1:0]   ppm_rate [NUM_AXES];
  logic [CHUNK_W-1:0] chunk_size;
  int                 frac_carry [NUM_AXES];

  pulse_result_t expected_moves [$];
  pulse_result_t got_res;
  pulse_result_t want_res;

  int  fail_count      = 0;
  int  moves_checked   = 0;
  int  reg_writes      = 0;
  int  saturated_seen  = 0;
  int  no_dominant_seen = 0;

  bit  src_gaps_on     = 1'b0;
  bit  sink_stalls_on  = 1'b0;
  int  sink_hold_left  = 0;

  axis_pulse_quantizer_top #(
    .AXES(NUM_AXES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  always #5 clk = ~clk;

  // watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // quantize one move against the shadow rates and advance the carries
  function automatic pulse_result_t quantize_move(input move_t mv);
    pulse_result_t     r;
    longint            span;
    longint            total;
    longint            whole;
    longint            rem;
    longint            mag;
    longint unsigned   size;
    longint unsigned   chunks;
    logic [MAG_W-1:0]  top_mag;
    r = '0;
    top_mag = '0;
    r.dominant_axis = AXIS_NONE;
    for (int a = 0; a < NUM_AXES; a++) begin
      span  = longint'($signed(mv.target[a])) - longint'($signed(mv.current[a]));
      total = span * longint'(ppm_rate[a])
            + longint'($signed(mv.missed[a])) * 65536
            + longint'(frac_carry[a]) * 256;
      // truncation toward zero, remainder keeps the sign of the sum
      whole = total / PULSE_ONE;
      rem   = total - whole * PULSE_ONE;
      frac_carry[a] = int'(rem / 256);
      mag = (whole > 0) ? whole : -whole;
      if (mag > MAG_LIMIT) mag = MAG_LIMIT;
      r.pulses[a]   = mag[MAG_W-1:0];
      r.negative[a] = (whole > 0) ? 1'b0 : 1'b1;
      // first axis with the strictly largest count wins
      if (mag[MAG_W-1:0] > top_mag) begin
        top_mag = mag[MAG_W-1:0];
        r.dominant_axis = dom_axis_t'(a);
      end
    end
    // a chunk size of zero counts as one
    size   = (chunk_size == '0) ? 64'd1 : 64'(chunk_size);
    chunks = (64'(top_mag) + size - 64'd1) / size;
    if (chunks > CHUNK_SAT) chunks = CHUNK_SAT;
    r.dominant_pulses = top_mag;
    r.chunk_count     = chunks[CHUNK_W-1:0];
    return r;
  endfunction

  function automatic move_t make_move(input logic [FIELD_W-1:0] tx, ty, tz,
                                      input logic [FIELD_W-1:0] cx, cy, cz,
                                      input logic [FIELD_W-1:0] mx, my, mz);
    move_t mv;
    mv.target  = {tz, ty, tx};
    mv.current = {cz, cy, cx};
    mv.missed  = {mz, my, mx};
    return mv;
  endfunction

  function automatic logic [FIELD_W-1:0] corner_field();
    case ($urandom_range(0, 4))
      0:       return POS_MIN;
      1:       return POS_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // mostly plausible planner moves, some raw noise and some corner values
  function automatic move_t random_move();
    move_t mv;
    int    pick;
    pick = $urandom_range(0, 9);
    for (int a = 0; a < NUM_AXES; a++) begin
      if (pick < 7) begin
        mv.current[a] = 32'($urandom_range(0, 1 << 28)) - 32'(1 << 27);
        mv.target[a]  = mv.current[a] + 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
        mv.missed[a]  = 32'($urandom_range(0, 1 << 13)) - 32'(1 << 12);
        if ($urandom_range(0, 7) == 0) mv.target[a] = mv.current[a];
      end else if (pick < 9) begin
        mv.current[a] = $urandom();
        mv.target[a]  = $urandom();
        mv.missed[a]  = $urandom();
      end else begin
        mv.current[a] = corner_field();
        mv.target[a]  = corner_field();
        mv.missed[a]  = corner_field();
      end
    end
    return mv;
  endfunction

  // offer one move, record its expected result once accepted
  task automatic send_move(input move_t mv);
    bit took;
    if (src_gaps_on && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= mv;
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    expected_moves.push_back(quantize_move(mv));
  endtask

  // stop offering and let every pending result come out
  task automatic drain_moves();
    s_tvalid <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // two-phase register write, shadow updated after the access edge
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    bit rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_CHUNK) chunk_size = value[CHUNK_W-1:0];
    else ppm_rate[int'(idx)] = value[PPM_W-1:0];
    reg_writes++;
  endtask

  task automatic write_all_rates(input logic [31:0] rx, ry, rz, chunk);
    write_reg(REG_PPM_X, rx);
    write_reg(REG_PPM_Y, ry);
    write_reg(REG_PPM_Z, rz);
    write_reg(REG_CHUNK, chunk);
  endtask

  // reset defaults: unit rate, chunk of one
  task automatic test_directed_defaults();
    send_move(make_move(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_move(make_move(ONE_MM, 0, 0, 0, 0, 0, 0, 0, 0));
    send_move(make_move(0, 0, 0, 0, ONE_MM, 0, 0, 0, 0));
    // half a pulse twice: carry turns into a whole pulse
    send_move(make_move(32'h8000, 0, 0, 0, 0, 0, 0, 0, 0));
    send_move(make_move(32'h8000, 0, 0, 0, 0, 0, 0, 0, 0));
    // missed pulses only, 3.5 on z
    send_move(make_move(0, 0, 0, 0, 0, 0, 0, 0, 32'h380));
    // ties go to the lower axis
    send_move(make_move(2 * ONE_MM, 2 * ONE_MM, 0, 0, 0, 0, 0, 0, 0));
    send_move(make_move(0, 3 * ONE_MM, 3 * ONE_MM, 0, 0, 0, 0, 0, 0));
    send_move(make_move(ONE_MM, 2 * ONE_MM, 5 * ONE_MM, 0, 0, 0, 0, 0, 0));
    // negative fraction below one pulse
    send_move(make_move(0, 0, 0, 32'h4000, 0, 0, 0, 0, 0));
    // widest spans in both directions drive the chunk count to its top value
    send_move(make_move(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN, 0, 0, 0));
    send_move(make_move(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX, 0, 0, 0));
    send_move(make_move(0, 0, 0, 0, 0, 0, POS_MAX, POS_MIN, '1));
    send_move(make_move(POS_MAX, POS_MIN, 0, POS_MIN, POS_MAX, 0, POS_MIN, POS_MAX, POS_MAX));
    drain_moves();
  endtask

  // rate and chunk registers at their extremes
  task automatic test_rate_extremes();
    write_all_rates(32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'h0);
    send_move(make_move(ONE_MM, 2 * ONE_MM, 32'h1, 0, 0, 0, 0, 0, 0));
    send_move(make_move(POS_MAX, 0, POS_MIN, POS_MIN, 0, POS_MAX, POS_MAX, 0, POS_MIN));
    send_move(make_move(0, 0, 0, 0, 0, 0, 32'h1, '1, 32'h80));
    drain_moves();
    write_all_rates(32'h0, 32'h0, 32'h0, 32'hFFFF);
    send_move(make_move(POS_MAX, POS_MIN, ONE_MM, POS_MIN, POS_MAX, 0, 0, 0, 0));
    send_move(make_move(0, 0, 0, 0, 0, 0, POS_MAX, 32'h100, POS_MIN));
    send_move(make_move(0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain_moves();
    write_all_rates(32'h1, 32'h100, 32'h7F_FFFF, 32'h1);
    send_move(make_move(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN, 0, 0, 0));
    send_move(make_move(ONE_MM, ONE_MM, ONE_MM, 0, 0, 0, POS_MIN, 0, 0));
    drain_moves();
  endtask

  // random registers per phase, random moves with idling on both sides
  task automatic test_random_moves();
    logic [31:0] rate [NUM_AXES];
    logic [31:0] chunk;
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        case ($urandom_range(0, 5))
          0:       rate[a] = 32'hFF_FFFF;
          1:       rate[a] = 32'h0;
          2:       rate[a] = $urandom_range(1, 255);
          3, 4:    rate[a] = $urandom_range(256, 1 << 15);
          default: rate[a] = $urandom() & 32'hFF_FFFF;
        endcase
      end
      case ($urandom_range(0, 4))
        0:       chunk = 32'h1;
        1:       chunk = 32'hFFFF;
        2:       chunk = $urandom_range(0, 64);
        3:       chunk = $urandom_range(65, 4096);
        default: chunk = $urandom() & 32'hFFFF;
      endcase
      write_all_rates(rate[0], rate[1], rate[2], chunk);
      repeat (PHASE_MOVES) send_move(random_move());
      drain_moves();
    end
  endtask

  // receiver holds off long enough for the block to back up into its input
  task automatic test_output_backpressure();
    src_gaps_on    = 1'b0;
    sink_hold_left = 600;
    repeat (12) send_move(random_move());
    drain_moves();
  endtask

  // closing stretch without any idling
  task automatic test_steady_stream();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    write_all_rates($urandom() & 32'hFF_FFFF, $urandom_range(1, 1 << 12),
                    32'h100, $urandom_range(1, 300));
    repeat (60) send_move(random_move());
    drain_moves();
  endtask

  // receiver pacing: long hold first, then random stall bursts
  initial begin : sink_pacing
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 17);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result check, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res = m_tdata;
      if (expected_moves.size() == 0) begin
        $error("unexpected result transaction: %h", m_tdata);
        fail_count++;
      end else begin
        want_res = expected_moves.pop_front();
        moves_checked++;
        // 8'd120 is the letter x, the axes follow in order
        for (int a = 0; a < NUM_AXES; a++) begin
          if (got_res.pulses[a] !== want_res.pulses[a]) begin
            $error("pulses_%c: expected %0d, actual %0d", 8'd120 + 8'(a),
                   want_res.pulses[a], got_res.pulses[a]);
            fail_count++;
          end
          if (got_res.negative[a] !== want_res.negative[a]) begin
            $error("negative_%c: expected %0d, actual %0d", 8'd120 + 8'(a),
                   want_res.negative[a], got_res.negative[a]);
            fail_count++;
          end
          if (want_res.pulses[a] == MAG_LIMIT[MAG_W-1:0]) saturated_seen++;
        end
        if (got_res.dominant_axis !== want_res.dominant_axis) begin
          $error("dominant_axis: expected %0d, actual %0d",
                 want_res.dominant_axis, got_res.dominant_axis);
          fail_count++;
        end
        if (got_res.dominant_pulses !== want_res.dominant_pulses) begin
          $error("dominant_pulses: expected %0d, actual %0d",
                 want_res.dominant_pulses, got_res.dominant_pulses);
          fail_count++;
        end
        if (got_res.chunk_count !== want_res.chunk_count) begin
          $error("chunk_count: expected %0d, actual %0d",
                 want_res.chunk_count, got_res.chunk_count);
          fail_count++;
        end
        if (want_res.dominant_axis == AXIS_NONE) no_dominant_seen++;
      end
    end
  end

  // test sequence
  initial begin
    for (int a = 0; a < NUM_AXES; a++) begin
      ppm_rate[a]   = 24'd256;
      frac_carry[a] = 0;
    end
    chunk_size = 16'd1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_rate_extremes();
    test_random_moves();
    test_output_backpressure();
    test_steady_stream();
    $display("checked %0d moves across %0d register writes", moves_checked, reg_writes);
    $display("saturated axis counts: %0d, moves with no dominant axis: %0d",
             saturated_seen, no_dominant_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
